/* sv/abe_pkg.sv */
// Shared types and constants for the angle bend energy pipeline.
// Used by the top level and by the angle rotation cell.
`default_nettype none

package abe_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BEND_SCALE   = 2'd0,
    CFG_CUBIC_COEFF  = 2'd1,
    CFG_LINEAR_SCALE = 2'd2
  } cfg_reg_t;

  localparam logic [23:0] BEND_SCALE_RST   = 24'd367790;
  localparam logic [23:0] CUBIC_COEFF_RST  = 24'hFE3679;  // -117127
  localparam logic [15:0] LINEAR_SCALE_RST = 16'd36847;

  // Angles in degrees, Q8.24
  localparam logic [30:0] ANGLE_90  = 31'd1509949440;
  localparam logic [31:0] ANGLE_180 = 32'd3019898880;

  // arctan(2^-i) in degrees, Q8.24
  typedef logic [31:0] atan_tab_t [32];
  localparam atan_tab_t ATAN_DEG = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
    32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
  };

  localparam logic signed [39:0] ENERGY_MAX = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] ENERGY_MIN = 40'sh8000000000;

  // One finished result
  typedef struct packed {
    logic signed [39:0] energy;
    logic               degenerate;
  } result_t;

endpackage

`default_nettype wire

/* sv/abe_sqrt_cell.sv */
// One digit step of a pipelined integer square root, for one or more lanes.
// Standalone; a chain of these forms the full root.
`default_nettype none

module abe_sqrt_cell #(
  parameter int LANES   = 1,
  parameter int SIDE_W  = 1,
  parameter int BIT_POS = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    valid_in,
  input  logic [LANES-1:0][63:0]  rad_in,
  input  logic [LANES-1:0][63:0]  root_in,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    valid_out,
  output logic [LANES-1:0][63:0]  rad_out,
  output logic [LANES-1:0][63:0]  root_out,
  output logic [SIDE_W-1:0]       side_out
);

  localparam logic [63:0] BIT_VAL = 64'd1 << BIT_POS;

  logic [LANES-1:0][63:0] trial;
  logic [LANES-1:0][63:0] rad_next;
  logic [LANES-1:0][63:0] root_next;

  // Subtract the trial value where it fits and set the root digit
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l] = root_in[l] + BIT_VAL;
      if (rad_in[l] >= trial[l]) begin
        rad_next[l]  = rad_in[l] - trial[l];
        root_next[l] = (root_in[l] >> 1) + BIT_VAL;
      end else begin
        rad_next[l]  = rad_in[l];
        root_next[l] = root_in[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_next;
      root_out <= root_next;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

/* sv/abe_div_cell.sv */
// One quotient bit of a pipelined restoring divider.
// Standalone; the first cell of a chain takes the integer bit without a shift.
`default_nettype none

module abe_div_cell #(
  parameter int FIRST  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  logic [63:0]       rem_in,
  input  logic [31:0]       quo_in,
  input  logic [63:0]       den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [63:0]       rem_out,
  output logic [31:0]       quo_out,
  output logic [63:0]       den_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [63:0] rem_sh;
  logic [31:0] quo_sh;
  logic [63:0] rem_next;
  logic [31:0] quo_next;

  // Shift in one bit, subtract the divisor where it fits
  always_comb begin
    rem_sh = (FIRST != 0) ? rem_in : {rem_in[62:0], 1'b0};
    quo_sh = (FIRST != 0) ? quo_in : {quo_in[30:0], 1'b0};
    if (rem_sh >= den_in) begin
      rem_next = rem_sh - den_in;
      quo_next = quo_sh | 32'd1;
    end else begin
      rem_next = rem_sh;
      quo_next = quo_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      quo_out  <= quo_next;
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

/* sv/abe_cordic_cell.sv */
// One vectoring rotation of the arctangent chain, angle kept in degrees.
// Depends on abe_pkg for the arctangent table.
`default_nettype none

module abe_cordic_cell #(
  parameter int ITER   = 0,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  logic signed [33:0] x_in,
  input  logic signed [33:0] y_in,
  input  logic signed [33:0] z_in,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               valid_out,
  output logic signed [33:0] x_out,
  output logic signed [33:0] y_out,
  output logic signed [33:0] z_out,
  output logic [SIDE_W-1:0]  side_out
);

  localparam logic signed [33:0] ATAN_STEP = $signed({2'b00, abe_pkg::ATAN_DEG[ITER]});

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] x_next;
  logic signed [33:0] y_next;
  logic signed [33:0] z_next;

  // Rotate toward the x axis and accumulate the angle
  always_comb begin
    xs = x_in >>> ITER;
    ys = y_in >>> ITER;
    if (!y_in[33]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN_STEP;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

/* sv/angle_bend_energy.sv */
// MMFF94 angle bend energy, one bend per clock while bend_stall is low.
// Depends on abe_pkg, abe_sqrt_cell, abe_div_cell and abe_cordic_cell.
//
// Input channel: bend_valid/bend_stall with the three packed atom positions,
// force constant, reference angle and linear flag. A transfer happens on a
// rising edge with bend_valid high and bend_stall low.
// Output channel: energy_valid/energy_stall with bend_energy and degenerate.
// Configuration: cfg_write/cfg_index/cfg_data, to be written by the user only
// while idle; the block does not enforce it. Throughput: one bend per cycle,
// sustained, whenever the output is taken. The path from input transfer to
// result valid runs through a chain of cells: two 31-step root chains, a
// 31-step divider chain and one rotation cell per angle iteration.
// The whole pipeline advances together; a two-entry output buffer holds
// results while energy_stall is high, and bend_stall rises only when that
// buffer is full. Reset empties the pipeline and buffer and loads the
// default register values; no clearing pass is needed.
`default_nettype none

module angle_bend_energy #(
  parameter int COORD_BITS       = 20,
  parameter int ANGLE_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               bend_valid,
  output logic               bend_stall,
  input  logic [59:0]        outer_a_position,
  input  logic [59:0]        centre_position,
  input  logic [59:0]        outer_b_position,
  input  logic [19:0]        force_constant,
  input  logic [15:0]        reference_angle,
  input  logic               linear_bend,
  output logic               energy_valid,
  input  logic               energy_stall,
  output logic signed [39:0] bend_energy,
  output logic               degenerate,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int CW         = COORD_BITS;
  localparam int LW         = 2 * CW + 2;
  localparam int DW         = 2 * CW + 3;
  localparam int FS_W       = LW + 39;
  localparam int AS_W       = FS_W + 12;
  localparam int BS_W       = 39;
  localparam int TS_W       = 70;
  localparam int NORM_STEPS = 5;
  localparam int SQ_STEPS   = 31;
  localparam int DIV_STEPS  = 31;
  localparam int NI         = ANGLE_ITERATIONS;

  // Configuration registers
  logic [23:0]        bend_scale;
  logic signed [23:0] cubic_coeff;
  logic [15:0]        linear_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      bend_scale   <= abe_pkg::BEND_SCALE_RST;
      cubic_coeff  <= abe_pkg::CUBIC_COEFF_RST;
      linear_scale <= abe_pkg::LINEAR_SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        abe_pkg::CFG_BEND_SCALE:   bend_scale   <= cfg_data;
        abe_pkg::CFG_CUBIC_COEFF:  cubic_coeff  <= cfg_data;
        abe_pkg::CFG_LINEAR_SCALE: linear_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance, held only when the output buffer is full
  logic [1:0] count;
  logic       en;
  assign en         = (count != 2'd2);
  assign bend_stall = !en;

  // Stage 1: unpack coordinates and form the two bond vectors
  logic [3*CW+59:0] pa_w, pc_w, pb_w;
  logic [2:0][CW:0] v1_next, v2_next;
  logic [2:0][CW:0] s1_v1, s1_v2;
  logic [36:0]      s1_side;
  logic             s1_valid;

  always_comb begin
    pa_w = {{(3 * CW){1'b0}}, outer_a_position};
    pc_w = {{(3 * CW){1'b0}}, centre_position};
    pb_w = {{(3 * CW){1'b0}}, outer_b_position};
    for (int k = 0; k < 3; k++) begin
      v1_next[k] = $signed({pa_w[k*CW+CW-1], pa_w[k*CW +: CW]})
                 - $signed({pc_w[k*CW+CW-1], pc_w[k*CW +: CW]});
      v2_next[k] = $signed({pb_w[k*CW+CW-1], pb_w[k*CW +: CW]})
                 - $signed({pc_w[k*CW+CW-1], pc_w[k*CW +: CW]});
    end
  end

  // Stage 2: products
  logic [2:0][LW-1:0] s2_sq1, s2_sq2, s2_dp;
  logic [36:0]        s2_side;
  logic               s2_valid;

  // Stage 3: sums, magnitude of the dot product
  logic [LW-1:0] s3_l1, s3_l2, s3_mag;
  logic          s3_neg, s3_degen;
  logic [36:0]   s3_side;
  logic          s3_valid;
  logic [LW-1:0] l1_sum, l2_sum;
  logic [DW-1:0] dot_sum;

  always_comb begin
    l1_sum  = s2_sq1[0] + s2_sq1[1] + s2_sq1[2];
    l2_sum  = s2_sq2[0] + s2_sq2[1] + s2_sq2[2];
    dot_sum = $signed({s2_dp[0][LW-1], s2_dp[0]}) + $signed({s2_dp[1][LW-1], s2_dp[1]})
            + $signed({s2_dp[2][LW-1], s2_dp[2]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= bend_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v1   <= v1_next;
      s1_v2   <= v2_next;
      s1_side <= {force_constant, reference_angle, linear_bend};
      for (int k = 0; k < 3; k++) begin
        s2_sq1[k] <= LW'($signed(s1_v1[k]) * $signed(s1_v1[k]));
        s2_sq2[k] <= LW'($signed(s1_v2[k]) * $signed(s1_v2[k]));
        s2_dp[k]  <= LW'($signed(s1_v1[k]) * $signed(s1_v2[k]));
      end
      s2_side  <= s1_side;
      s3_l1    <= l1_sum;
      s3_l2    <= l2_sum;
      s3_neg   <= dot_sum[DW-1];
      s3_mag   <= dot_sum[DW-1] ? LW'(-dot_sum) : dot_sum[LW-1:0];
      s3_degen <= (l1_sum == '0) || (l2_sum == '0);
      s3_side  <= s2_side;
    end
  end

  // Normalize both squared lengths by even shifts into [2^60, 2^62)
  logic [1:0][61:0]  nl [NORM_STEPS+1];
  logic [1:0][5:0]   ne [NORM_STEPS+1];
  logic [FS_W-1:0]   ns [NORM_STEPS+1];
  logic              nv [NORM_STEPS+1];

  assign nl[0] = {62'(s3_l2), 62'(s3_l1)};
  assign ne[0] = '0;
  assign ns[0] = {s3_mag, s3_neg, s3_degen, s3_side};
  assign nv[0] = s3_valid;

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    always_ff @(posedge clk) begin
      if (rst) begin
        nv[j+1] <= 1'b0;
      end else if (en) begin
        nv[j+1] <= nv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ns[j+1] <= ns[j];
        for (int l = 0; l < 2; l++) begin
          if (nl[j][l][61 -: SH] == '0) begin
            nl[j+1][l] <= nl[j][l] << SH;
            ne[j+1][l] <= ne[j][l] + 6'(SH);
          end else begin
            nl[j+1][l] <= nl[j][l];
            ne[j+1][l] <= ne[j][l];
          end
        end
      end
    end
  end

  // Square roots of both normalized lengths
  logic [1:0][63:0] rad_a  [SQ_STEPS+1];
  logic [1:0][63:0] root_a [SQ_STEPS+1];
  logic [AS_W-1:0]  side_a [SQ_STEPS+1];
  logic             val_a  [SQ_STEPS+1];

  assign rad_a[0]  = {{2'b00, nl[NORM_STEPS][1]}, {2'b00, nl[NORM_STEPS][0]}};
  assign root_a[0] = '0;
  assign side_a[0] = {ne[NORM_STEPS][1], ne[NORM_STEPS][0], ns[NORM_STEPS]};
  assign val_a[0]  = nv[NORM_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqa
    abe_sqrt_cell #(.LANES(2), .SIDE_W(AS_W), .BIT_POS(2 * (SQ_STEPS - 1 - i))) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(val_a[i]), .rad_in(rad_a[i]), .root_in(root_a[i]), .side_in(side_a[i]),
      .valid_out(val_a[i+1]), .rad_out(rad_a[i+1]), .root_out(root_a[i+1]),
      .side_out(side_a[i+1])
    );
  end

  // Divisor from the two roots, dividend from the rescaled dot magnitude
  logic [AS_W-1:0] a_side;
  logic [6:0]      esum;
  logic [61:0]     m_den;
  logic [63:0]     m_num;
  logic [BS_W-1:0] m_side;
  logic            m_valid;

  assign a_side = side_a[SQ_STEPS];
  assign esum   = {1'b0, a_side[FS_W +: 6]} + {1'b0, a_side[FS_W+6 +: 6]};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= val_a[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_den  <= root_a[SQ_STEPS][0][30:0] * root_a[SQ_STEPS][1][30:0];
      m_num  <= 64'(a_side[39 +: LW]) << esum[6:1];
      m_side <= a_side[BS_W-1:0];
    end
  end

  // Cosine magnitude to 30 fraction bits
  logic [63:0]     rem_d  [DIV_STEPS+1];
  logic [31:0]     quo_d  [DIV_STEPS+1];
  logic [63:0]     den_d  [DIV_STEPS+1];
  logic [BS_W-1:0] side_d [DIV_STEPS+1];
  logic            val_d  [DIV_STEPS+1];

  assign rem_d[0]  = m_num;
  assign quo_d[0]  = '0;
  assign den_d[0]  = {2'b00, m_den};
  assign side_d[0] = m_side;
  assign val_d[0]  = m_valid;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    abe_div_cell #(.FIRST((i == 0) ? 1 : 0), .SIDE_W(BS_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(val_d[i]), .rem_in(rem_d[i]), .quo_in(quo_d[i]), .den_in(den_d[i]),
      .side_in(side_d[i]),
      .valid_out(val_d[i+1]), .rem_out(rem_d[i+1]), .quo_out(quo_d[i+1]),
      .den_out(den_d[i+1]), .side_out(side_d[i+1])
    );
  end

  // Clamp cosine, then square it for the sine
  logic [31:0]     dq;
  logic [30:0]     qc_next;
  logic [BS_W-1:0] dside;
  logic [30:0]     p1_q, p2_q;
  logic [BS_W-1:0] p1_side, p2_side;
  logic [61:0]     p2_qq;
  logic            p1_valid, p2_valid;

  assign dq      = quo_d[DIV_STEPS];
  assign dside   = side_d[DIV_STEPS];
  assign qc_next = (dq > 32'h4000_0000) ? 31'h4000_0000 : dq[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= val_d[DIV_STEPS];
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_q    <= qc_next;
      p1_side <= {dside[38] && (qc_next != '0), dside[37:0]};
      p2_q    <= p1_q;
      p2_qq   <= p1_q * p1_q;
      p2_side <= p1_side;
    end
  end

  // Sine root
  logic [0:0][63:0] rad_b  [SQ_STEPS+1];
  logic [0:0][63:0] root_b [SQ_STEPS+1];
  logic [TS_W-1:0]  side_b [SQ_STEPS+1];
  logic             val_b  [SQ_STEPS+1];

  assign rad_b[0]  = (64'd1 << 60) - {2'b00, p2_qq};
  assign root_b[0] = '0;
  assign side_b[0] = {p2_q, p2_side};
  assign val_b[0]  = p2_valid;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqb
    abe_sqrt_cell #(.LANES(1), .SIDE_W(TS_W), .BIT_POS(2 * (SQ_STEPS - 1 - i))) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(val_b[i]), .rad_in(rad_b[i]), .root_in(root_b[i]), .side_in(side_b[i]),
      .valid_out(val_b[i+1]), .rad_out(rad_b[i+1]), .root_out(root_b[i+1]),
      .side_out(side_b[i+1])
    );
  end

  // Angle from (cos, sin)
  logic signed [33:0] cx [NI+1];
  logic signed [33:0] cy [NI+1];
  logic signed [33:0] cz [NI+1];
  logic [TS_W-1:0]    cs [NI+1];
  logic               cv [NI+1];

  assign cx[0] = $signed({3'b000, side_b[SQ_STEPS][69:39]});
  assign cy[0] = $signed({3'b000, root_b[SQ_STEPS][0][30:0]});
  assign cz[0] = '0;
  assign cs[0] = side_b[SQ_STEPS];
  assign cv[0] = val_b[SQ_STEPS];

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    abe_cordic_cell #(.ITER(i), .SIDE_W(TS_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(cv[i]), .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .side_in(cs[i]),
      .valid_out(cv[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1]),
      .side_out(cs[i+1])
    );
  end

  // Energy tail
  logic [TS_W-1:0]    t_side;
  logic signed [33:0] zf;
  logic [30:0]        zc;
  logic [31:0]        theta;
  logic signed [34:0] dsum;
  logic [31:0]        opsum;
  logic [30:0]        tq;
  logic [19:0]        tka;

  assign t_side = cs[NI];
  assign zf     = cz[NI];
  assign tq     = t_side[69:39];
  assign tka    = t_side[36:17];

  always_comb begin
    if (zf[33]) begin
      zc = '0;
    end else if (zf > $signed({3'b000, abe_pkg::ANGLE_90})) begin
      zc = abe_pkg::ANGLE_90;
    end else begin
      zc = zf[30:0];
    end
    theta = t_side[38] ? (abe_pkg::ANGLE_180 - {1'b0, zc}) : {1'b0, zc};
    dsum  = $signed({3'b000, theta}) - $signed({3'b000, t_side[16:1], 16'd0})
          + 35'sd128;
    opsum = (t_side[38] ? (32'h4000_0000 - {1'b0, tq}) : (32'h4000_0000 + {1'b0, tq}))
          + 32'd8192;
  end

  logic [5:0]         ev;
  logic [5:0]         elin;
  logic [5:0]         edeg;
  logic signed [25:0] e1_d16;
  logic [17:0]        e1_op16;
  logic [43:0]        e1_kkp;
  logic [35:0]        e1_lkp;
  logic [48:0]        e2_sq;
  logic signed [49:0] e2_cd;
  logic [28:0]        e2_kk;
  logic [53:0]        e2_linp;
  logic [32:0]        e3_sq16;
  logic signed [26:0] e3_f16;
  logic [30:0]        e3_line;
  logic [28:0]        e3_kk;
  logic [61:0]        e4_ap;
  logic signed [26:0] e4_f16;
  logic [30:0]        e4_line;
  logic [37:0]        e5_a16;
  logic signed [26:0] e5_f16;
  logic [30:0]        e5_line;
  logic signed [65:0] e6_ep;
  logic [30:0]        e6_line;

  logic [51:0]        sq_full;
  logic [44:0]        kkr;
  logic [49:0]        sqr;
  logic signed [49:0] cdr;
  logic [54:0]        linr;
  logic [62:0]        apr;

  assign sq_full = 52'($signed(e1_d16) * $signed(e1_d16));
  assign kkr     = {1'b0, e1_kkp} + 45'd32768;
  assign sqr     = {1'b0, e2_sq} + 50'd32768;
  assign cdr     = e2_cd + 50'sd8388608;
  assign linr    = {1'b0, e2_linp} + 55'd8388608;
  assign apr     = {1'b0, e4_ap} + 63'd8388608;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
    end else if (en) begin
      ev <= {ev[4:0], cv[NI]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      elin <= {elin[4:0], t_side[0]};
      edeg <= {edeg[4:0], t_side[37]};
      // angle offset, linear term and force products
      e1_d16  <= dsum[33:8];
      e1_op16 <= opsum[31:14];
      e1_kkp  <= bend_scale * tka;
      e1_lkp  <= linear_scale * tka;
      // squares and scalings
      e2_sq   <= sq_full[48:0];
      e2_cd   <= cubic_coeff * e1_d16;
      e2_kk   <= kkr[44:16];
      e2_linp <= e1_lkp * e1_op16;
      // round to Q.16
      e3_sq16 <= sqr[48:16];
      e3_f16  <= $signed({cdr[49], cdr[49:24]}) + 27'sd65536;
      e3_line <= linr[54:24];
      e3_kk   <= e2_kk;
      // quadratic term
      e4_ap   <= e3_kk * e3_sq16;
      e4_f16  <= e3_f16;
      e4_line <= e3_line;
      e5_a16  <= apr[61:24];
      e5_f16  <= e4_f16;
      e5_line <= e4_line;
      // cubic factor
      e6_ep   <= $signed({1'b0, e5_a16}) * e5_f16;
      e6_line <= e5_line;
    end
  end

  // Final rounding, formula select, saturation
  logic signed [65:0] epr;
  logic signed [49:0] ener;
  abe_pkg::result_t   res_next;

  always_comb begin
    epr  = e6_ep + 66'sd32768;
    ener = elin[5] ? $signed({19'd0, e6_line}) : epr[65:16];
    res_next.degenerate = edeg[5];
    if (edeg[5]) begin
      res_next.energy = '0;
    end else if ((ener[49:39] == '0) || (ener[49:39] == '1)) begin
      res_next.energy = ener[39:0];
    end else if (ener[49]) begin
      res_next.energy = abe_pkg::ENERGY_MIN;
    end else begin
      res_next.energy = abe_pkg::ENERGY_MAX;
    end
  end

  // Two-entry output buffer
  abe_pkg::result_t buf0, buf1;
  logic             push, pop;

  assign push = en && ev[5];
  assign pop  = (count != 2'd0) && !energy_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          buf0 <= res_next;
        end else begin
          buf1 <= res_next;
        end
      end
      2'b01: begin
        buf0 <= buf1;
      end
      2'b11: begin
        buf0 <= res_next;
      end
      default: ;
    endcase
  end

  assign energy_valid = (count != 2'd0);
  assign bend_energy  = buf0.energy;
  assign degenerate   = buf0.degenerate;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("output buffer count out of range");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2) else $error("push into a full output buffer");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    energy_valid && degenerate |-> bend_energy == '0)
    else $error("degenerate bend with nonzero energy");

endmodule

`default_nettype wire

/* dv/tb_angle_bend_energy.sv */
// Self-checking testbench for angle_bend_energy: random and directed bends,
// register settings, random valid gaps and output stalls. Depends on abe_pkg.
`default_nettype none

module tb_angle_bend_energy;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CBITS = 20;
  localparam int ITERS = 24;
  localparam int LATENCY = ITERS + 111;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic bend_valid = 0;
  logic bend_stall;
  logic [59:0] outer_a_position = '0;
  logic [59:0] centre_position = '0;
  logic [59:0] outer_b_position = '0;
  logic [19:0] force_constant = '0;
  logic [15:0] reference_angle = '0;
  logic linear_bend = 0;
  logic energy_valid;
  logic energy_stall = 0;
  logic signed [39:0] bend_energy;
  logic degenerate;
  logic cfg_write = 0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Register copies used by the predictor
  logic [23:0] bend_scale_q = abe_pkg::BEND_SCALE_RST;
  logic signed [23:0] cubic_coeff_q = abe_pkg::CUBIC_COEFF_RST;
  logic [15:0] linear_scale_q = abe_pkg::LINEAR_SCALE_RST;

  abe_pkg::result_t expected_energies[$];
  int bends_sent = 0;
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit no_idle = 0;

  angle_bend_energy #(.COORD_BITS(CBITS), .ANGLE_ITERATIONS(ITERS)) dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint coord_of(logic [59:0] p, int k);
    logic signed [CBITS-1:0] raw;
    raw = p[k*CBITS +: CBITS];
    return longint'(raw);
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Normalize a squared length to at least 2^60 and take its root
  function automatic longint unsigned norm_root(longint unsigned len2, output int sh);
    sh = 0;
    while (len2 < (64'd1 << 60)) begin
      len2 <<= 2;
      sh += 2;
    end
    return int_sqrt(len2);
  endfunction

  function automatic abe_pkg::result_t predict_bend(
      logic [59:0] pa, logic [59:0] pc, logic [59:0] pb,
      logic [19:0] ka_in, logic [15:0] ref_in, logic lin);
    abe_pkg::result_t r;
    longint v1, v2, dot, energy, cosq, x, y, z, xs, ys, theta, d16, a16, f16, kk;
    longint unsigned l1, l2, s1, s2, den, mag, num, q, rem, sq, sq16, ka, ref_deg;
    int e1, e2;
    dot = 0; l1 = 0; l2 = 0; energy = 0;
    ka = ka_in;
    ref_deg = ref_in;
    for (int k = 0; k < 3; k++) begin
      v1 = coord_of(pa, k) - coord_of(pc, k);
      v2 = coord_of(pb, k) - coord_of(pc, k);
      l1 += v1 * v1;
      l2 += v2 * v2;
      dot += v1 * v2;
    end
    if (l1 == 0 || l2 == 0) begin
      r.energy = '0;
      r.degenerate = 1;
      return r;
    end
    // Cosine magnitude, Q1.30
    s1 = norm_root(l1, e1);
    s2 = norm_root(l2, e2);
    den = s1 * s2;
    mag = (dot < 0) ? -dot : dot;
    num = mag << ((e1 + e2) / 2);
    q = num / den;
    rem = num % den;
    for (int i = 0; i < 30; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    cosq = (dot < 0) ? -longint'(q) : longint'(q);
    if (lin) begin
      energy = rnd_shift(longint'(linear_scale_q) * longint'(ka) *
                         (((64'sd1 << 30) + cosq + (64'sd1 << 13)) >>> 14), 24);
    end else begin
      // Vectoring rotation for the angle in degrees
      x = q;
      y = int_sqrt((64'd1 << 60) - q * q);
      z = 0;
      for (int i = 0; i < ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z += longint'(abe_pkg::ATAN_DEG[i]);
        end else begin
          x = x - ys; y = y + xs; z -= longint'(abe_pkg::ATAN_DEG[i]);
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(abe_pkg::ANGLE_90)) z = longint'(abe_pkg::ANGLE_90);
      theta = (cosq < 0) ? longint'(abe_pkg::ANGLE_180) - z : z;
      d16 = rnd_shift(theta - longint'(ref_deg << 16), 8);
      sq = d16 * d16;
      sq16 = (sq + (64'd1 << 15)) >> 16;
      kk = (longint'(bend_scale_q) * longint'(ka) + (64'sd1 << 15)) >>> 16;
      a16 = rnd_shift(kk * longint'(sq16), 24);
      f16 = (64'sd1 << 16) + rnd_shift(longint'(cubic_coeff_q) * d16, 24);
      energy = rnd_shift(a16 * f16, 16);
    end
    if (energy > longint'(abe_pkg::ENERGY_MAX)) energy = longint'(abe_pkg::ENERGY_MAX);
    if (energy < longint'(abe_pkg::ENERGY_MIN)) energy = longint'(abe_pkg::ENERGY_MIN);
    r.energy = energy[39:0];
    r.degenerate = 0;
    return r;
  endfunction

  // Sample both channels, predict on input transfers, check output transfers
  always @(posedge clk) begin
    abe_pkg::result_t exp_r;
    if (!rst) begin
      if (bend_valid && !bend_stall) begin
        expected_energies.insert(expected_energies.size(),
                                 predict_bend(outer_a_position, centre_position,
                                              outer_b_position, force_constant,
                                              reference_angle, linear_bend));
        bends_sent++;
      end
      if (energy_valid && !energy_stall) begin
        if (expected_energies.size() == 0) begin
          $display("%0t: unexpected result energy=%0d degenerate=%0b",
                   $time, bend_energy, degenerate);
          errors++;
        end else begin
          exp_r = expected_energies.pop_front();
          if (bend_energy !== exp_r.energy) begin
            $display("%0t: bend_energy expected %0d actual %0d", $time, exp_r.energy,
                     bend_energy);
            errors++;
          end
          if (degenerate !== exp_r.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b", $time, exp_r.degenerate,
                     degenerate);
            errors++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 4);
      end
      if ((bend_valid && !bend_stall) || (energy_valid && !energy_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Hold off the output side per result
  always @(negedge clk) begin
    energy_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  task automatic send_bend(logic [59:0] pa, logic [59:0] pc, logic [59:0] pb,
                           logic [19:0] ka, logic [15:0] ref_deg, logic lin);
    int gap;
    int sent_before;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      bend_valid = 0;
      repeat (gap) @(negedge clk);
    end
    outer_a_position = pa;
    centre_position = pc;
    outer_b_position = pb;
    force_constant = ka;
    reference_angle = ref_deg;
    linear_bend = lin;
    bend_valid = 1;
    sent_before = bends_sent;
    do @(negedge clk); while (bends_sent == sent_before);
  endtask

  task automatic drain_bends();
    bend_valid = 0;
    while (expected_energies.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 0;
    case (idx)
      abe_pkg::CFG_BEND_SCALE:   bend_scale_q = value;
      abe_pkg::CFG_CUBIC_COEFF:  cubic_coeff_q = value;
      abe_pkg::CFG_LINEAR_SCALE: linear_scale_q = value[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [59:0] pack_xyz(longint x, longint y, longint z);
    logic [CBITS-1:0] xr, yr, zr;
    xr = x[CBITS-1:0];
    yr = y[CBITS-1:0];
    zr = z[CBITS-1:0];
    return {zr, yr, xr};
  endfunction

  // Offset a centre by a random vector of random magnitude
  function automatic logic [59:0] near_point(logic [59:0] c);
    int mag;
    mag = $urandom_range(1, CBITS);
    return pack_xyz(coord_of(c, 0) + $signed($urandom_range(0, (1 << mag) - 1)) - (1 << (mag-1)),
                    coord_of(c, 1) + $signed($urandom_range(0, (1 << mag) - 1)) - (1 << (mag-1)),
                    coord_of(c, 2) + $signed($urandom_range(0, (1 << mag) - 1)) - (1 << (mag-1)));
  endfunction

  task automatic test_directed_bends();
    logic [59:0] o, px, py, nx, far_pos, far_neg;
    o = pack_xyz(0, 0, 0);
    px = pack_xyz(1024, 0, 0);
    py = pack_xyz(0, 1024, 0);
    nx = pack_xyz(-1024, 0, 0);
    far_pos = pack_xyz(524287, 524287, 524287);
    far_neg = pack_xyz(-524288, -524288, -524288);
    // zero-length vector, both formulas
    send_bend(o, o, px, 20'd65536, 16'd28160, 0);
    send_bend(px, o, o, 20'd65536, 16'd28160, 1);
    send_bend(far_pos, far_pos, far_neg, 20'hFFFFF, 16'd0, 0);
    // straight, reversed and right angles
    send_bend(px, o, px, 20'd65536, 16'd0, 0);
    send_bend(px, o, nx, 20'd65536, 16'd46080, 0);
    send_bend(px, o, py, 20'd65536, 16'd23040, 0);
    send_bend(px, o, nx, 20'hFFFFF, 16'd0, 0);
    send_bend(px, o, px, 20'hFFFFF, 16'd46080, 0);
    send_bend(px, o, nx, 20'd65536, 16'd46080, 1);
    send_bend(px, o, px, 20'hFFFFF, 16'd0, 1);
    send_bend(px, o, py, 20'd0, 16'd0, 1);
    // coordinate extremes
    send_bend(far_pos, far_neg, far_pos, 20'hFFFFF, 16'hFFFF, 0);
    send_bend(far_neg, far_pos, pack_xyz(524287, -524288, 524287), 20'hFFFFF, 16'd0, 0);
    send_bend(far_pos, far_neg, pack_xyz(-524288, 524287, 0), 20'h12345, 16'd30000, 1);
    // reference angle beyond 180 degrees and zero force constant
    send_bend(px, o, py, 20'hFFFFF, 16'hFFFF, 0);
    send_bend(px, o, py, 20'd0, 16'd12345, 0);
    send_bend(pack_xyz(3, 1, 0), o, pack_xyz(1, 3, 0), 20'h80000, 16'd15360, 0);
    drain_bends();
  endtask

  task automatic test_random_bends(int count);
    logic [59:0] c, a, b;
    logic [15:0] ref_deg;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      c = 60'({$urandom, $urandom});
      a = ($urandom_range(0, 19) == 0) ? c : near_point(c);
      b = ($urandom_range(0, 19) == 0) ? c : near_point(c);
      if ($urandom_range(0, 9) == 0) begin
        a = 60'({$urandom, $urandom});
        b = 60'({$urandom, $urandom});
      end
      ref_deg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46080));
      send_bend(a, c, b, 20'($urandom), ref_deg, $urandom_range(0, 3) == 0);
    end
    no_idle = 0;
    drain_bends();
  endtask

  task automatic test_register_settings(logic [23:0] bs, logic [23:0] cc, logic [15:0] ls,
                                        int count);
    write_reg(abe_pkg::CFG_BEND_SCALE, bs);
    write_reg(abe_pkg::CFG_CUBIC_COEFF, cc);
    write_reg(abe_pkg::CFG_LINEAR_SCALE, {8'($urandom), ls});
    // unmapped index must leave the registers alone
    write_reg(CFG_UNUSED, 24'($urandom));
    test_random_bends(count);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 0;
    test_directed_bends();
    test_random_bends(300);
    test_register_settings(24'hFFFFFF, 24'h7FFFFF, 16'hFFFF, 80);
    test_register_settings(24'h000000, 24'h800000, 16'h0000, 60);
    test_register_settings(24'hFFFFFF, 24'h800000, 16'h8000, 80);
    test_register_settings(24'($urandom), 24'($urandom), 16'($urandom), 80);
    test_register_settings(abe_pkg::BEND_SCALE_RST, abe_pkg::CUBIC_COEFF_RST,
                           abe_pkg::LINEAR_SCALE_RST, 80);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/abe_pkg.sv
sv/abe_sqrt_cell.sv
sv/abe_div_cell.sv
sv/abe_cordic_cell.sv
sv/angle_bend_energy.sv
dv/tb_angle_bend_energy.sv
